// File: design/scd_pkg.sv
package scd_pkg;

  // Field widths of the input and result transactions
  localparam int unsigned OpW   = 2;
  localparam int unsigned ByteW = 8;
  localparam int unsigned IdxW  = 12;
  localparam int unsigned LenW  = 13;

  // Default sizes of the two stores
  localparam int unsigned FrameCapacityDef = 4096;
  localparam int unsigned ConsoleDepthDef  = 256;

  // SLIP special bytes
  localparam logic [ByteW-1:0] ByteEnd    = 8'hC0;
  localparam logic [ByteW-1:0] ByteEsc    = 8'hDB;
  localparam logic [ByteW-1:0] ByteEscEnd = 8'hDC;
  localparam logic [ByteW-1:0] ByteEscEsc = 8'hDD;

  // Configuration port
  localparam int unsigned ApbAddrW = 3;
  localparam int unsigned ApbDataW = 32;
  localparam logic        RegEnable = 1'b0;

  typedef enum logic [OpW-1:0] {
    OpWire    = 2'd0,
    OpPop     = 2'd1,
    OpRead    = 2'd2,
    OpRelease = 2'd3
  } op_e;

  typedef struct packed {
    logic [OpW-1:0]   operation;
    logic [ByteW-1:0] wire_byte;
    logic [IdxW-1:0]  read_index;
  } in_item_t;

  typedef struct packed {
    logic [ByteW-1:0] read_data;
    logic             read_valid;
    logic             frame_waiting;
    logic [LenW-1:0]  frame_length;
    logic             console_available;
    logic             console_dropped;
  } out_item_t;

  // Item after decode in the front end
  typedef struct packed {
    op_e              op;
    logic [ByteW-1:0] raw;
    logic [ByteW-1:0] unesc;
    logic             is_end;
    logic             is_esc;
    logic [IdxW-1:0]  index;
  } cls_item_t;

  // Control from the register block to the back end
  typedef struct packed {
    logic enable;
    logic clear;
  } cfg_ctrl_t;

endpackage

// File: design/slip_console_demultiplexer_top.sv
// SLIP / console receive demultiplexer. One transaction per cycle is taken on
// the input channel (wire byte, console pop, frame byte read or frame release)
// and each gives exactly one result transaction, in order. From acceptance a
// transaction passes through the input queue, the execute stage (state update,
// store write, store read issue) and the registered store read before the
// output queue. While the output is not stalled, the sustained rate is one
// transaction per cycle, set by the single execute stage and the one write and
// one read port of each store. Both channels stall independently; the
// output queue holds three results. The enable register (byte address 0)
// clears the ring, frame state and flags when written from 0 to 1; write it
// only with no transaction in flight.
module slip_console_demultiplexer_top #(
  parameter int unsigned FrameCapacity = scd_pkg::FrameCapacityDef,
  parameter int unsigned ConsoleDepth  = scd_pkg::ConsoleDepthDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  scd_pkg::in_item_t               in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output scd_pkg::out_item_t              out_data_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [scd_pkg::ApbAddrW-1:0]    paddr,
  input  logic [scd_pkg::ApbDataW-1:0]    pwdata,
  output logic [scd_pkg::ApbDataW-1:0]    prdata,
  output logic                            pready
);
  import scd_pkg::*;

  logic      enable_q;
  logic      reg_wr;
  cfg_ctrl_t cfg;
  logic      q_push_valid, q_push_ready;
  cls_item_t q_push_data;
  logic      q_pop_valid, q_pop_ready;
  cls_item_t q_pop_data;
  logic [1:0] q_count;

  // Register access
  assign pready = 1'b1;
  assign reg_wr = psel && penable && pwrite && (paddr[2] == RegEnable);
  assign prdata = (paddr[2] == RegEnable) ? {{(ApbDataW-1){1'b0}}, enable_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
    end else if (reg_wr) begin
      enable_q <= pwdata[0];
    end
  end

  assign cfg.enable = enable_q;
  assign cfg.clear  = reg_wr && pwdata[0] && !enable_q;

  scd_front u_front (
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .item_i       (in_data_i),
    .push_valid_o (q_push_valid),
    .push_ready_i (q_push_ready),
    .item_o       (q_push_data)
  );

  scd_fifo #(
    .T     (cls_item_t),
    .Depth (2)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (q_push_valid),
    .push_ready_o (q_push_ready),
    .push_data_i  (q_push_data),
    .pop_valid_o  (q_pop_valid),
    .pop_ready_i  (q_pop_ready),
    .pop_data_o   (q_pop_data),
    .count_o      (q_count)
  );

  scd_back #(
    .FrameCapacity (FrameCapacity),
    .ConsoleDepth  (ConsoleDepth)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .item_valid_i (q_pop_valid),
    .item_ready_o (q_pop_ready),
    .item_i       (q_pop_data),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

  // Queue occupancy stays consistent with its valid flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_valid == (q_count != 2'd0))
    else $error("input queue valid and occupancy disagree");

  // Enable changes only through a register write
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !reg_wr |=> $stable(enable_q))
    else $error("enable changed without a write");

  // Clear is issued only on a rising enable
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg.clear |=> enable_q)
    else $error("clear without enable set");

endmodule

// File: design/scd_fifo.sv
module scd_fifo #(
  parameter type         T     = logic,
  parameter int unsigned Depth = 2
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_valid_i,
  output logic                       push_ready_o,
  input  T                           push_data_i,
  output logic                       pop_valid_o,
  input  logic                       pop_ready_i,
  output T                           pop_data_o,
  output logic [$clog2(Depth+1)-1:0] count_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  T                mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push, pop;

  assign push_ready_o = (cnt_q < CntW'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign count_o      = cnt_q;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Pointer and occupancy update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// File: design/scd_front.sv
module scd_front (
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  scd_pkg::in_item_t item_i,
  output logic              push_valid_o,
  input  logic              push_ready_i,
  output scd_pkg::cls_item_t item_o
);
  import scd_pkg::*;

  // Handshake goes straight to the queue
  assign push_valid_o = in_valid_i;
  assign in_ready_o   = push_ready_i;

  // Decode the operation and pre-classify the wire byte
  always_comb begin
    item_o.op     = op_e'(item_i.operation);
    item_o.raw    = item_i.wire_byte;
    item_o.is_end = (item_i.wire_byte == ByteEnd);
    item_o.is_esc = (item_i.wire_byte == ByteEsc);
    item_o.index  = item_i.read_index;
    // value the byte takes when it follows an ESC
    case (item_i.wire_byte)
      ByteEscEnd: item_o.unesc = ByteEnd;
      ByteEscEsc: item_o.unesc = ByteEsc;
      default:    item_o.unesc = item_i.wire_byte;
    endcase
  end

endmodule

// File: design/scd_back.sv
module scd_back #(
  parameter int unsigned FrameCapacity = scd_pkg::FrameCapacityDef,
  parameter int unsigned ConsoleDepth  = scd_pkg::ConsoleDepthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  scd_pkg::cfg_ctrl_t  cfg_i,
  input  logic                item_valid_i,
  output logic                item_ready_o,
  input  scd_pkg::cls_item_t  item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output scd_pkg::out_item_t  out_data_o
);
  import scd_pkg::*;

  localparam int unsigned CountW   = $clog2(FrameCapacity + 1);
  localparam int unsigned FaW      = $clog2(FrameCapacity);
  localparam int unsigned PosW     = $clog2(ConsoleDepth);
  localparam int unsigned CmpW     = (CountW > IdxW) ? CountW : IdxW;
  localparam int unsigned OutDepth = 3;
  localparam int unsigned OcW      = $clog2(OutDepth + 1);

  typedef enum logic [1:0] {
    SrcNone,
    SrcConsole,
    SrcFrame
  } src_e;

  // Live state
  logic [PosW-1:0]   cons_wp_q, cons_wp_d;
  logic [PosW-1:0]   cons_rp_q, cons_rp_d;
  logic              framing_q, framing_d;
  logic              esc_q, esc_d;
  logic [CountW-1:0] frame_cnt_q, frame_cnt_d;
  logic              frame_done_q, frame_done_d;

  // Stores
  logic [ByteW-1:0] cons_mem [ConsoleDepth];
  logic [ByteW-1:0] frame_mem [FrameCapacity];
  logic [ByteW-1:0] cons_rd_q, frame_rd_q;
  logic             cons_we, frame_we;
  logic [FaW-1:0]   frame_wa, frame_ra;
  logic [ByteW-1:0] frame_wd;

  // Result staging
  logic              pend_valid_q;
  out_item_t         pend_q, res;
  src_e              pend_src_q, src;
  out_item_t         merged;
  logic [OcW-1:0]    out_cnt;
  logic [OcW:0]      used;
  logic              out_push_ready;
  logic              issue;

  logic [PosW-1:0]   wp_nxt, rp_nxt;
  logic [CmpW-1:0]   idx_ext, cnt_ext, cap_ext;
  logic [ByteW-1:0]  dec_byte;

  // Issue only with a free slot for this transaction in the output queue
  assign used         = {1'b0, out_cnt} + {{OcW{1'b0}}, pend_valid_q};
  assign issue        = item_valid_i && (used < (OcW + 1)'(OutDepth));
  assign item_ready_o = issue;

  assign wp_nxt = (cons_wp_q == PosW'(ConsoleDepth - 1)) ? '0 : cons_wp_q + PosW'(1);
  assign rp_nxt = (cons_rp_q == PosW'(ConsoleDepth - 1)) ? '0 : cons_rp_q + PosW'(1);

  assign idx_ext  = CmpW'(item_i.index);
  assign cnt_ext  = CmpW'(frame_cnt_q);
  assign cap_ext  = CmpW'(FrameCapacity);
  assign frame_ra = idx_ext[FaW-1:0];
  assign dec_byte = esc_q ? item_i.unesc : item_i.raw;

  // Execute one transaction
  always_comb begin
    cons_wp_d    = cons_wp_q;
    cons_rp_d    = cons_rp_q;
    framing_d    = framing_q;
    esc_d        = esc_q;
    frame_cnt_d  = frame_cnt_q;
    frame_done_d = frame_done_q;
    cons_we      = 1'b0;
    frame_we     = 1'b0;
    frame_wa     = frame_cnt_q[FaW-1:0];
    frame_wd     = dec_byte;
    src          = SrcNone;
    res          = '0;
    if (issue) begin
      case (item_i.op)
        OpWire: begin
          if (cfg_i.enable) begin
            if (item_i.is_end) begin
              if (framing_q && frame_cnt_q != '0) begin
                framing_d    = 1'b0;
                frame_done_d = 1'b1;
              end else begin
                framing_d   = 1'b1;
                frame_cnt_d = '0;
              end
              esc_d = 1'b0;
            end else if (framing_q) begin
              if (!esc_q && item_i.is_esc) begin
                esc_d = 1'b1;
              end else begin
                esc_d = 1'b0;
                if (frame_cnt_q >= CountW'(FrameCapacity)) begin
                  // overflow: drop the frame
                  frame_cnt_d = '0;
                  if (frame_cnt_q != '0) begin
                    framing_d = 1'b0;
                  end
                end else begin
                  frame_we    = 1'b1;
                  frame_cnt_d = frame_cnt_q + CountW'(1);
                end
              end
            end else if (wp_nxt == cons_rp_q) begin
              res.console_dropped = 1'b1;
            end else begin
              cons_we   = 1'b1;
              cons_wp_d = wp_nxt;
            end
          end
        end
        OpPop: begin
          if (cons_wp_q != cons_rp_q) begin
            src            = SrcConsole;
            res.read_valid = 1'b1;
            cons_rp_d      = rp_nxt;
          end
        end
        OpRead: begin
          if (frame_done_q && idx_ext < cnt_ext && idx_ext < cap_ext) begin
            src            = SrcFrame;
            res.read_valid = 1'b1;
          end
        end
        OpRelease: begin
          if (frame_done_q) begin
            frame_done_d = 1'b0;
            frame_cnt_d  = '0;
          end
        end
        default: begin
        end
      endcase
    end
    res.frame_waiting     = frame_done_d;
    res.frame_length      = LenW'(frame_cnt_d);
    res.console_available = cfg_i.enable && (cons_wp_d != cons_rp_d);
  end

  // State registers; enabling clears the live state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cons_wp_q    <= '0;
      cons_rp_q    <= '0;
      framing_q    <= 1'b0;
      esc_q        <= 1'b0;
      frame_cnt_q  <= '0;
      frame_done_q <= 1'b0;
      pend_valid_q <= 1'b0;
    end else begin
      pend_valid_q <= issue;
      if (cfg_i.clear) begin
        cons_wp_q    <= '0;
        cons_rp_q    <= '0;
        framing_q    <= 1'b0;
        esc_q        <= 1'b0;
        frame_cnt_q  <= '0;
        frame_done_q <= 1'b0;
      end else begin
        cons_wp_q    <= cons_wp_d;
        cons_rp_q    <= cons_rp_d;
        framing_q    <= framing_d;
        esc_q        <= esc_d;
        frame_cnt_q  <= frame_cnt_d;
        frame_done_q <= frame_done_d;
      end
    end
  end

  // Result fields are registered alongside the store read data
  always_ff @(posedge clk_i) begin
    pend_q     <= res;
    pend_src_q <= src;
  end

  // Console ring store
  always_ff @(posedge clk_i) begin
    if (cons_we) begin
      cons_mem[cons_wp_q] <= item_i.raw;
    end
    cons_rd_q <= cons_mem[cons_rp_q];
  end

  // Frame store
  always_ff @(posedge clk_i) begin
    if (frame_we) begin
      frame_mem[frame_wa] <= frame_wd;
    end
    frame_rd_q <= frame_mem[frame_ra];
  end

  // Merge read data into the staged result
  always_comb begin
    merged = pend_q;
    case (pend_src_q)
      SrcConsole: merged.read_data = cons_rd_q;
      SrcFrame:   merged.read_data = frame_rd_q;
      default:    merged.read_data = '0;
    endcase
  end

  scd_fifo #(
    .T     (out_item_t),
    .Depth (OutDepth)
  ) u_out_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (pend_valid_q),
    .push_ready_o (out_push_ready),
    .push_data_i  (merged),
    .pop_valid_o  (out_valid_o),
    .pop_ready_i  (out_ready_i),
    .pop_data_o   (out_data_o),
    .count_o      (out_cnt)
  );

  // A staged result always finds room in the output queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_valid_q |-> out_push_ready)
    else $error("output queue full with a staged result");

  // Escape state only exists inside a frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    esc_q |-> framing_q)
    else $error("escape pending outside a frame");

  // Frame count never passes the store capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_cnt_q <= CountW'(FrameCapacity))
    else $error("frame count beyond capacity");

  // Every issued transaction is staged in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue |=> pend_valid_q)
    else $error("issued transaction not staged");

endmodule
